// File: sv/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SQW_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SQW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/sqw_pkg.sv
// types, constants and constant tables of the square wave partial sum unit
package sqw_pkg;

  localparam int MAX_TERMS      = 64;
  localparam int PHASE_BITS     = 16;
  localparam int SINE_ADDR_BITS = 10;
  localparam int OUT_FRAC_BITS  = 16;

  localparam int PHASE_W = 16;
  localparam int TC_W    = 7;
  localparam int OUT_W   = 18;
  localparam logic [TC_W-1:0] TC_RESET = 7'd15;

  localparam int NUM_CELLS  = (MAX_TERMS + 1) / 2;
  localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int NT_W       = $clog2(NUM_CELLS + 1);
  localparam int CYC_W      = $clog2(NUM_CELLS + 6);

  localparam int ADDR_TOT  = SINE_ADDR_BITS + 2;
  localparam int QUARTER   = 2 ** SINE_ADDR_BITS;
  localparam int TABLE_LEN = QUARTER + 1;
  localparam int IDX_W     = SINE_ADDR_BITS + 1;

  localparam int SINE_W = 31;
  localparam int COEF_W = 31;
  localparam int PROD_W = SINE_W + COEF_W;
  localparam int TERM_W = PROD_W - 30;
  localparam int ACC_W  = TERM_W + CELL_IDX_W + 2;

  localparam int OUT_SH     = 30 - OUT_FRAC_BITS;
  localparam int ROUND_HALF = (1 << OUT_SH) >> 1;
  localparam int OUT_MAX    = 2 ** (OUT_W - 1) - 1;

  localparam logic [63:0] Q30_ONE          = 64'd1073741824;
  localparam logic [63:0] HALFPI_Q30       = 64'd1686629713;
  localparam logic [63:0] FOUR_OVER_PI_Q30 = 64'd1367130551;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [SINE_W-1:0]     sine_t;
  typedef logic [COEF_W-1:0]     coef_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef sine_t sine_tab_t [TABLE_LEN];
  typedef coef_t coef_tab_t [NUM_CELLS];
  typedef int    int_tab_t  [NUM_CELLS];
  typedef logic [63:0] taylor_tab_t [9];

  localparam taylor_tab_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                         64'd156, 64'd210, 64'd272, 64'd342};

  // folded sine lookup of one harmonic phase
  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] idx;
  } cell_tap_t;

  // one harmonic handed to the multiply-accumulate pipe
  typedef struct packed {
    logic                  vld;
    logic                  neg;
    logic [IDX_W-1:0]      idx;
    logic [CELL_IDX_W-1:0] harm;
  } issue_t;

  function automatic sine_tab_t sine_table();
    sine_tab_t         tab;
    logic [63:0]       x;
    logic [63:0]       t;
    logic signed [63:0] acc;
    logic              neg;
    for (int k = 0; k < TABLE_LEN; k++) begin
      x = (64'(k) * HALFPI_Q30 + (64'd1 << (SINE_ADDR_BITS - 1))) >> SINE_ADDR_BITS;
      t = x;
      acc = $signed(x);
      neg = 1'b1;
      for (int m = 0; m < 9; m++) begin
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / TAYLOR_DIV[m];
        if (neg) begin
          acc = acc - $signed(t);
        end else begin
          acc = acc + $signed(t);
        end
        neg = !neg;
      end
      if (acc < 0) begin
        acc = '0;
      end
      if (acc > $signed(Q30_ONE)) begin
        acc = $signed(Q30_ONE);
      end
      tab[k] = acc[SINE_W-1:0];
    end
    return tab;
  endfunction

  function automatic int_tab_t harm_numbers();
    int_tab_t tab;
    for (int j = 0; j < NUM_CELLS; j++) begin
      tab[j] = 2 * j + 1;
    end
    return tab;
  endfunction

  localparam int_tab_t HARM_NUM = harm_numbers();

  function automatic coef_tab_t coef_table();
    coef_tab_t   tab;
    logic [63:0] c;
    for (int j = 0; j < NUM_CELLS; j++) begin
      c = (FOUR_OVER_PI_Q30 + 64'(j)) / HARM_NUM[j];
      tab[j] = c[COEF_W-1:0];
    end
    return tab;
  endfunction

endpackage

// File: sv/sqw_cell.sv
// one harmonic cell: holds an odd harmonic phase and folds it to a quarter-wave index
module sqw_cell (
  input  logic               clk,
  input  logic               en,
  input  sqw_pkg::phase_t    ph_in,
  input  sqw_pkg::phase_t    step,
  output sqw_pkg::phase_t    ph_out,
  output sqw_pkg::cell_tap_t tap
);
  import sqw_pkg::*;

  phase_t                       ph_r;
  logic [PHASE_BITS+ADDR_TOT-1:0] wide;
  logic [ADDR_TOT-1:0]          addr;
  logic [SINE_ADDR_BITS-1:0]    k;
  logic [1:0]                   quad;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= ph_in + step;
    end
  end

  assign wide = {ph_r, {ADDR_TOT{1'b0}}};
  assign addr = wide[PHASE_BITS+ADDR_TOT-1 -: ADDR_TOT];
  assign k    = addr[SINE_ADDR_BITS-1:0];
  assign quad = addr[ADDR_TOT-1 -: 2];

  assign ph_out  = ph_r;
  assign tap.neg = quad[1];
  assign tap.idx = quad[0] ? (IDX_W'(QUARTER) - {1'b0, k}) : {1'b0, k};

endmodule

// File: sv/sqw_sine_rom.sv
// quarter-wave sine rom, unsigned q1.30, registered read
module sqw_sine_rom (
  input  logic                     clk,
  input  logic [sqw_pkg::IDX_W-1:0] idx,
  output sqw_pkg::sine_t           data
);
  import sqw_pkg::*;

  localparam sine_tab_t SINE_TAB = sine_table();

  sine_t data_r;

  always_ff @(posedge clk) begin
    data_r <= SINE_TAB[idx];
  end

  assign data = data_r;

endmodule

// File: sv/sqw_mac.sv
// shared multiply-accumulate pipe: sine lookup, coefficient product, rounding, sum
module sqw_mac (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  sqw_pkg::issue_t  iss,
  output sqw_pkg::acc_t    acc
);
  import sqw_pkg::*;

  localparam coef_tab_t COEF_TAB = coef_table();

  sine_t             sine_q;
  coef_t             coef_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_rnd;
  logic [TERM_W-1:0] term_r;
  logic              v2_r, v3_r, v4_r;
  logic              neg2_r, neg3_r, neg4_r;
  acc_t              acc_r;
  acc_t              term_ext;

  sqw_sine_rom u_rom (
    .clk  (clk),
    .idx  (iss.idx),
    .data (sine_q)
  );

  assign prod_rnd = prod_r + PROD_W'(Q30_ONE >> 1);
  assign term_ext = acc_t'({{(ACC_W-TERM_W){1'b0}}, term_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= iss.vld;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    coef_r <= COEF_TAB[iss.harm];
    neg2_r <= iss.neg;
    prod_r <= coef_r * sine_q;
    neg3_r <= neg2_r;
    term_r <= prod_rnd[PROD_W-1:30];
    neg4_r <= neg3_r;
    if (clear) begin
      acc_r <= '0;
    end else if (v4_r) begin
      acc_r <= neg4_r ? (acc_r - term_ext) : (acc_r + term_ext);
    end
  end

  assign acc = acc_r;

endmodule

// File: sv/square_wave_fourier_partial_sum_unit.sv
// top level of the square wave fourier partial sum unit
// input channel in_valid / in_ready carries one phase item, 65536 per full turn
// result channel out_valid / out_ready carries one signed q2.16 wave_sum item
// cfg_wr_en with cfg_wr_data sets term_count (odd harmonics up to it summed), write only when idle
// a row of 32 cells builds the odd harmonic phases, one new cell filled per cycle
// one harmonic per cycle enters a shared rom / multiply / accumulate pipe
// items are summed one at a time, each sending all 32 harmonic slots through the shared pipe
// in_ready is high only while idle; an item may be taken while a result still waits
// a stalled result holds in the output register; the next sum waits behind it
// reset (rst_n low, synchronous) empties the output, idles the unit, term_count = 15
// the sine and coefficient tables are constants, no fill pass after reset
`include "assert_macros.svh"

module square_wave_fourier_partial_sum_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sqw_pkg::PHASE_W-1:0]      in_phase,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [sqw_pkg::OUT_W-1:0] out_wave_sum,
  input  logic                             cfg_wr_en,
  input  logic [sqw_pkg::TC_W-1:0]         cfg_wr_data
);
  import sqw_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ABS, ST_OUT} state_t;

  localparam int ISSUE_LAST = NUM_CELLS;
  localparam int RUN_LAST   = NUM_CELLS + 4;

  state_t                  state_r;
  logic [CYC_W-1:0]        cyc_r;
  logic [TC_W-1:0]         term_count_r;
  logic [NT_W-1:0]         n_terms_r;
  logic [NT_W-1:0]         n_terms_nxt;
  logic [TC_W-1:0]         cnt_clamp;
  logic [TC_W:0]           cnt_plus;
  phase_t                  phase_r;
  phase_t                  step_r;
  issue_t                  iss_r;
  issue_t                  iss_nxt;
  logic [CYC_W-1:0]        sel_w;
  logic [CELL_IDX_W-1:0]   sel;
  logic                    issue_on;
  logic                    run;
  logic                    accept;
  logic                    out_load;
  acc_t                    acc;
  logic                    sgn_r;
  logic [ACC_W-1:0]        mag_r;
  logic [ACC_W-1:0]        rnd;
  logic signed [OUT_W-1:0] sat;
  logic signed [OUT_W-1:0] out_wave_sum_r;
  logic                    out_valid_r;

  phase_t    cell_in [NUM_CELLS];
  phase_t    cell_ph [NUM_CELLS];
  cell_tap_t taps    [NUM_CELLS];

  assign run      = (state_r == ST_RUN);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign cell_in[0] = phase_r - step_r;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign cell_in[g] = cell_ph[g-1];
    end
    sqw_cell u_cell (
      .clk    (clk),
      .en     (run),
      .ph_in  (cell_in[g]),
      .step   (step_r),
      .ph_out (cell_ph[g]),
      .tap    (taps[g])
    );
  end

  sqw_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (accept),
    .iss   (iss_r),
    .acc   (acc)
  );

  // odd harmonics up to the clamped term count
  always_comb begin
    cnt_clamp   = (int'(term_count_r) > MAX_TERMS) ? TC_W'(MAX_TERMS) : term_count_r;
    cnt_plus    = {1'b0, cnt_clamp} + (TC_W+1)'(1);
    n_terms_nxt = NT_W'(cnt_plus[TC_W:1]);
  end

  // pick the cell filled in the previous cycle
  always_comb begin
    sel_w        = cyc_r - CYC_W'(1);
    sel          = sel_w[CELL_IDX_W-1:0];
    issue_on     = run && (cyc_r >= CYC_W'(1)) && (cyc_r <= CYC_W'(ISSUE_LAST));
    iss_nxt.vld  = issue_on && (sel < n_terms_r);
    iss_nxt.neg  = taps[sel].neg;
    iss_nxt.idx  = taps[sel].idx;
    iss_nxt.harm = sel;
  end

  // round half away from zero, then saturate
  always_comb begin
    rnd = (mag_r + ACC_W'(ROUND_HALF)) >> OUT_SH;
    if (!sgn_r) begin
      sat = (rnd > ACC_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : rnd[OUT_W-1:0];
    end else begin
      sat = (rnd > ACC_W'(OUT_MAX + 1)) ? OUT_W'(-(OUT_MAX + 1)) : -rnd[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cyc_r        <= '0;
      iss_r        <= '0;
      out_valid_r  <= 1'b0;
      term_count_r <= TC_RESET;
    end else begin
      if (cfg_wr_en) begin
        term_count_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      iss_r <= iss_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            phase_r   <= in_phase[PHASE_BITS-1:0];
            step_r    <= {in_phase[PHASE_BITS-2:0], 1'b0};
            n_terms_r <= n_terms_nxt;
            cyc_r     <= '0;
            state_r   <= ST_RUN;
          end
        end
        ST_RUN: begin
          cyc_r <= cyc_r + CYC_W'(1);
          if (cyc_r == CYC_W'(RUN_LAST)) begin
            state_r <= ST_ABS;
          end
        end
        ST_ABS: begin
          sgn_r   <= acc[ACC_W-1];
          mag_r   <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_wave_sum_r <= sat;
            state_r        <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_wave_sum = out_wave_sum_r;

  `SQW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, state_r == ST_RUN && !in_ready)
  `SQW_ASSERT_IMPLIES(a_cyc_bound, state_r == ST_RUN, cyc_r <= CYC_W'(RUN_LAST))
  `SQW_ASSERT_IMPLIES(a_issue_in_run, iss_r.vld, $past(state_r == ST_RUN))
  `SQW_ASSERT_NEXT(a_result_loaded, state_r == ST_OUT && (!out_valid_r || out_ready),
                   out_valid && state_r == ST_IDLE)

endmodule

// File: bench/square_wave_fourier_partial_sum_unit_tb.sv
// self-checking testbench of the square wave fourier partial sum unit
`timescale 1ns / 100ps

module square_wave_fourier_partial_sum_unit_tb;

  localparam int SINE_ADDR_BITS = 10;
  localparam int QUARTER        = 1 << SINE_ADDR_BITS;
  localparam int MAX_TERMS      = 64;
  localparam int OUT_SH         = 14;
  localparam longint unsigned HALFPI_Q30       = 64'd1686629713;
  localparam longint unsigned FOUR_OVER_PI_Q30 = 64'd1367130551;
  localparam longint unsigned Q30_ONE          = 64'd1073741824;
  localparam longint signed   SUM_MAX          = 131071;
  localparam longint signed   SUM_MIN          = -131072;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [sqw_pkg::PHASE_W-1:0] in_phase = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [sqw_pkg::OUT_W-1:0] out_wave_sum;
  logic cfg_wr_en = 1'b0;
  logic [sqw_pkg::TC_W-1:0] cfg_wr_data = '0;

  logic [30:0] quarter_sine [0:QUARTER];
  logic [sqw_pkg::TC_W-1:0] term_count_now = sqw_pkg::TC_RESET;
  logic [sqw_pkg::PHASE_W-1:0] pending_phases [$];
  logic signed [sqw_pkg::OUT_W-1:0] expected_sums [$];
  int error_count = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_cnt = 0;
  logic hold_start = 1'b0;
  bit no_idle = 1'b0;

  square_wave_fourier_partial_sum_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_phase    (in_phase),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_wave_sum(out_wave_sum),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [30:0] taylor_sine(longint unsigned x);
    longint unsigned t;
    longint signed acc;
    bit sub;
    t = x;
    acc = $signed(x);
    sub = 1'b1;
    for (int n = 3; n <= 19; n += 2) begin
      t = (t * x) >> 30;
      t = ((t * x) >> 30) / longint'((n - 1) * n);
      if (sub) begin
        acc = acc - $signed(t);
      end else begin
        acc = acc + $signed(t);
      end
      sub = !sub;
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > $signed(Q30_ONE)) begin
      acc = $signed(Q30_ONE);
    end
    return acc[30:0];
  endfunction

  function automatic longint signed harmonic_sine(logic [15:0] hp);
    logic [11:0] addr;
    logic [10:0] k;
    longint signed v;
    addr = hp[15:4];
    k = {1'b0, addr[9:0]};
    if (addr[10]) begin
      k = 11'(QUARTER) - k;
    end
    v = longint'(quarter_sine[k]);
    return addr[11] ? -v : v;
  endfunction

  function automatic logic signed [17:0] partial_sum(logic [15:0] phase,
                                                      logic [6:0] count);
    int n_terms;
    longint signed acc;
    longint signed s;
    longint signed r;
    longint unsigned coef;
    longint unsigned mag;
    longint unsigned term;
    longint unsigned m;
    n_terms = (count > MAX_TERMS) ? MAX_TERMS : int'(count);
    acc = 0;
    for (int i = 1; i <= n_terms; i += 2) begin
      coef = (FOUR_OVER_PI_Q30 + longint'(i / 2)) / longint'(i);
      s = harmonic_sine(16'(phase * i));
      mag = (s < 0) ? -s : s;
      term = (coef * mag + (Q30_ONE >> 1)) >> 30;
      if (s < 0) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    m = (acc < 0) ? -acc : acc;
    m = (m + (64'd1 << (OUT_SH - 1))) >> OUT_SH;
    if (m > (64'd1 << 20)) begin
      m = 64'd1 << 20;
    end
    r = (acc < 0) ? -$signed(m) : $signed(m);
    if (r > SUM_MAX) begin
      r = SUM_MAX;
    end
    if (r < SUM_MIN) begin
      r = SUM_MIN;
    end
    return r[17:0];
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [15:0] random_phase();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return 16'($urandom);
    end else if (r < 8) begin
      return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 32) - 16);
    end
    return {12'($urandom), 4'b0};
  endfunction

  // sender: one item offered at a time, random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_sums.push_back(partial_sum(in_phase, term_count_now));
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_phases.size() != 0) begin
          in_valid <= 1'b1;
          in_phase <= pending_phases.pop_front();
          send_gap <= idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_start) begin
      hold_cnt <= HOLD_CYCLES;
    end
  end

  // receiver: checks each item against the oldest expected sum
  always @(posedge clk) begin
    logic signed [sqw_pkg::OUT_W-1:0] want;
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      stall = recv_stall;
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $error("wave_sum: unexpected item, actual %0d", out_wave_sum);
          end
        end else begin
          want = expected_sums.pop_front();
          if (out_wave_sum !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $error("wave_sum mismatch: expected %0d, actual %0d", want, out_wave_sum);
            end
          end
        end
        stall = idle_length();
      end else if (stall != 0) begin
        stall = stall - 1;
      end
      recv_stall <= stall;
      out_ready <= (hold_cnt == 0) && (stall == 0);
    end
  end

  // checked between edges so that no item can still start
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_phases.size() != 0 || in_valid || expected_sums.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_term_count(input logic [sqw_pkg::TC_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    term_count_now = value;
  endtask

  task automatic load_phases(input logic [15:0] list [$]);
    @(negedge clk);
    foreach (list[j]) begin
      pending_phases.push_back(list[j]);
    end
  endtask

  initial begin
    logic [15:0] batch [$];
    logic [6:0] tc_pick;
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_sine[k] = taylor_sine((longint'(k) * HALFPI_Q30
                                     + (64'd1 << (SINE_ADDR_BITS - 1))) >> SINE_ADDR_BITS);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset term count, quadrant edges and field extremes
    batch = '{16'd0, 16'd1, 16'd16383, 16'd16384, 16'd16385, 16'd32768,
              16'd49152, 16'd65535, 16'd8192, 16'h5555};
    load_phases(batch);
    // zero terms
    set_term_count(7'd0);
    batch = '{16'h4000, 16'hC000};
    load_phases(batch);
    set_term_count(7'd1);
    batch = '{16'h4000, 16'hC000, 16'h2AAA};
    load_phases(batch);
    set_term_count(7'd64);
    batch = '{16'h0010, 16'h4000, 16'h7FF0, 16'hFFFF};
    load_phases(batch);
    // more terms than the unit holds
    set_term_count(7'd127);
    batch = '{16'h0010, 16'h4000, 16'hAAAA};
    load_phases(batch);
    set_term_count(7'd2);
    batch = '{16'h4000, 16'h1234};
    load_phases(batch);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: tc_pick = 7'd64;
        1: tc_pick = 7'd1;
        2: tc_pick = 7'd127;
        3: tc_pick = 7'd0;
        4: tc_pick = 7'd63;
        5: tc_pick = 7'd65;
        default: tc_pick = 7'($urandom_range(0, 127));
      endcase
      set_term_count(tc_pick);
      no_idle = (p % 4 == 1);
      batch.delete();
      for (int j = 0; j < 200; j++) begin
        batch.push_back(random_phase());
      end
      load_phases(batch);
      if (p % 3 == 0) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_sums.size() != 0) begin
        $error("wave_sum: %0d expected items never arrived", expected_sums.size());
      end
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/sqw_pkg.sv
sv/sqw_cell.sv
sv/sqw_sine_rom.sv
sv/sqw_mac.sv
sv/square_wave_fourier_partial_sum_unit.sv
bench/square_wave_fourier_partial_sum_unit_tb.sv
